@@ src/ms_adpcm_block_decoder_macros.svh @@
// Assertion macros for the ADPCM block decoder checker.
// Needs nothing else; included by the checker file.
`ifndef MS_ADPCM_BLOCK_DECODER_MACROS_SVH
`define MS_ADPCM_BLOCK_DECODER_MACROS_SVH

// check a property on the rising clock, off during reset
`define MSADPCM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// check a property on the rising clock, reset included
`define MSADPCM_ASSERT_RST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ src/msadpcm_pkg.sv @@
// Shared constants and coefficient tables of the ADPCM block decoder.
// No dependencies.
package msadpcm_pkg;

  localparam int MAX_BLOCK_BYTES_DEF = 4096;
  localparam int MAX_CHANNELS        = 2;

  localparam int ADDR_W = 4;
  localparam int COEF_W = 11;

  localparam logic [1:0] REG_CHANNELS    = 2'd0;
  localparam logic [1:0] REG_BLOCK_ALIGN = 2'd1;
  localparam logic [1:0] REG_FRAMES      = 2'd2;

  localparam logic [1:0]  CHANNELS_RST = 2'd1;
  localparam logic [12:0] ALIGN_RST    = 13'd256;
  localparam logic [13:0] FRAMES_RST   = 14'd500;

  localparam logic [2:0] PRED_MAX = 3'd6;

  function automatic logic signed [COEF_W-1:0] adapt_coef(input logic [3:0] code);
    logic signed [COEF_W-1:0] v;
    unique case (code)
      4'd4, 4'd12:         v = 11'sd307;
      4'd5, 4'd11:         v = 11'sd409;
      4'd6, 4'd10:         v = 11'sd512;
      4'd7, 4'd9:          v = 11'sd614;
      4'd8:                v = 11'sd768;
      default:             v = 11'sd230;
    endcase
    return v;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_first(input logic [2:0] idx);
    logic signed [COEF_W-1:0] v;
    unique case (idx)
      3'd0:    v = 11'sd256;
      3'd1:    v = 11'sd512;
      3'd2:    v = 11'sd0;
      3'd3:    v = 11'sd192;
      3'd4:    v = 11'sd240;
      3'd5:    v = 11'sd460;
      default: v = 11'sd392;
    endcase
    return v;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_second(input logic [2:0] idx);
    logic signed [COEF_W-1:0] v;
    unique case (idx)
      3'd0:    v = 11'sd0;
      3'd1:    v = -11'sd256;
      3'd2:    v = 11'sd0;
      3'd3:    v = 11'sd64;
      3'd4:    v = 11'sd0;
      3'd5:    v = -11'sd208;
      default: v = -11'sd232;
    endcase
    return v;
  endfunction

endpackage

@@ src/ms_adpcm_block_decoder.sv @@
// MS ADPCM block decoder: byte stream in, 16-bit PCM samples out, APB registers.
// Depends on msadpcm_pkg.
//
//   channel   dir  handshake                   payload
//   byte      in   byte_valid / byte_ready     byte_value
//   sample    out  sample_valid / sample_ready sample, channel_id, last, block_end
//   config    in   APB psel/penable/pwrite     paddr, pwdata -> prdata
//
// A header byte is taken in ST_IDLE; the final header byte moves to ST_SEED, which hands out
// the seeds, two for mono or four for stereo. Each decoded code of a data byte runs ST_MUL0 to
// ST_MUL3 on the one shared 16x11 multiplier that serves predictor, code and step adaption.
// Reset is synchronous; there is no clearing pass.
// A stalled sample output holds the sequencer before it loads the next sample; the final
// sample of a byte waits in the output register while the next byte is accepted.
module ms_adpcm_block_decoder #(
  parameter int MAX_BLOCK_BYTES = msadpcm_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msadpcm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  input  logic [7:0]                      byte_value,
  output logic                            sample_valid,
  input  logic                            sample_ready,
  output logic signed [15:0]              sample,
  output logic                            channel_id,
  output logic                            last,
  output logic                            block_end
);
  import msadpcm_pkg::*;

  localparam int BPW = $clog2(MAX_BLOCK_BYTES);
  localparam logic [13:0] ALIGN_CAP = 14'(MAX_BLOCK_BYTES);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SEED = 6'b000010,
    ST_MUL0 = 6'b000100,
    ST_MUL1 = 6'b001000,
    ST_MUL2 = 6'b010000,
    ST_MUL3 = 6'b100000
  } state_t;

  state_t state;

  logic [1:0]  channels_r;
  logic [12:0] block_align_r;
  logic [13:0] frames_r;

  logic [BPW-1:0]     byte_pos;
  logic [14:0]        samples_emitted;
  logic [2:0]         predictor_index [2];
  logic signed [15:0] step_delta      [2];
  logic signed [15:0] previous_sample [2];
  logic signed [15:0] older_sample    [2];
  logic [7:0]         low_byte_hold;

  logic [1:0]         seed_cnt;
  logic [7:0]         code_byte;
  logic               code_sel;
  logic               chan;
  logic signed [27:0] acc;

  logic        stereo;
  logic [3:0]  hdr;
  logic [14:0] limit;
  logic [13:0] align;
  logic [13:0] pos14;
  logic [13:0] pos_inc;
  logic [BPW-1:0] pos_next;
  logic        in_header;
  logic        in_pred;
  logic        last_hdr;
  logic [3:0]  q;
  logic [1:0]  field;
  logic        hdr_ch;
  logic        in_acc;
  logic        out_free;
  logic        out_load;
  logic        cfg_we;

  logic        seed_last;
  logic        seed_ch;
  logic        seed_older;

  logic [2:0]  pidx;
  logic [3:0]  code;
  logic signed [15:0] mul_x;
  logic signed [COEF_W-1:0] mul_y;
  logic signed [26:0] prod;
  logic signed [27:0] prod_ext;
  logic signed [26:0] delta_shift;
  logic signed [15:0] delta_wrap;
  logic signed [15:0] delta_new;
  logic signed [15:0] sat;
  logic [14:0] se_inc;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_CHANNELS:    prdata = {30'd0, channels_r};
      REG_BLOCK_ALIGN: prdata = {19'd0, block_align_r};
      REG_FRAMES:      prdata = {18'd0, frames_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign stereo   = channels_r[1] && (MAX_CHANNELS >= 2);
  assign hdr      = stereo ? 4'd14 : 4'd7;
  assign limit    = stereo ? {frames_r, 1'b0} : {1'b0, frames_r};
  assign align    = ({1'b0, block_align_r} > ALIGN_CAP) ? ALIGN_CAP : {1'b0, block_align_r};
  assign pos14    = 14'(byte_pos);
  assign pos_inc  = pos14 + 14'd1;
  assign pos_next = (pos_inc >= align) ? '0 : pos_inc[BPW-1:0];

  assign in_header = pos14 < {10'd0, hdr};
  assign in_pred   = pos14 < (stereo ? 14'd2 : 14'd1);
  assign last_hdr  = pos14 == {10'd0, hdr - 4'd1};
  assign q         = byte_pos[3:0] - (stereo ? 4'd2 : 4'd1);
  assign field     = stereo ? q[3:2] : q[2:1];
  assign hdr_ch    = stereo ? q[1] : 1'b0;

  assign byte_ready = state == ST_IDLE;
  assign in_acc     = byte_valid && byte_ready;
  assign out_free   = !sample_valid || sample_ready;
  assign out_load   = ((state == ST_SEED) || (state == ST_MUL3)) && out_free;

  assign seed_last  = seed_cnt == (stereo ? 2'd3 : 2'd1);
  assign seed_ch    = stereo ? seed_cnt[0] : 1'b0;
  assign seed_older = stereo ? !seed_cnt[1] : !seed_cnt[0];

  assign pidx = (predictor_index[chan] > PRED_MAX) ? PRED_MAX : predictor_index[chan];
  assign code = code_sel ? code_byte[3:0] : code_byte[7:4];

  always_comb begin
    unique case (state)
      ST_MUL1: begin
        mul_x = older_sample[chan];
        mul_y = coef_second(pidx);
      end
      ST_MUL2: begin
        mul_x = step_delta[chan];
        mul_y = {{(COEF_W-4){code[3]}}, code};
      end
      ST_MUL3: begin
        mul_x = step_delta[chan];
        mul_y = adapt_coef(code);
      end
      default: begin
        mul_x = previous_sample[chan];
        mul_y = coef_first(pidx);
      end
    endcase
  end

  assign prod        = mul_x * mul_y;
  assign prod_ext    = {prod[26], prod};
  assign delta_shift = prod >>> 8;
  assign delta_wrap  = delta_shift[15:0];
  assign delta_new   = (delta_wrap < 16'sd16) ? 16'sd16 : delta_wrap;
  assign se_inc      = samples_emitted + 15'd1;

  always_comb begin
    priority if (acc > 28'sd32767) begin
      sat = 16'sh7fff;
    end else if (acc < -28'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = acc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      channels_r      <= CHANNELS_RST;
      block_align_r   <= ALIGN_RST;
      frames_r        <= FRAMES_RST;
      byte_pos        <= '0;
      samples_emitted <= '0;
      low_byte_hold   <= '0;
      sample_valid    <= 1'b0;
      seed_cnt        <= '0;
      code_sel        <= 1'b0;
      chan            <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        predictor_index[i] <= '0;
        step_delta[i]      <= '0;
        previous_sample[i] <= '0;
        older_sample[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (paddr[3:2])
          REG_CHANNELS:    channels_r    <= pwdata[1:0];
          REG_BLOCK_ALIGN: block_align_r <= pwdata[12:0];
          REG_FRAMES:      frames_r      <= pwdata[13:0];
          default:         ;
        endcase
      end

      if (out_load) begin
        sample_valid <= 1'b1;
      end else if (sample_ready) begin
        sample_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            byte_pos <= pos_next;
            if (in_header) begin
              if (pos14 == 14'd0) begin
                samples_emitted <= '0;
              end
              if (in_pred) begin
                predictor_index[byte_pos[0]] <=
                  (byte_value > 8'd6) ? PRED_MAX : byte_value[2:0];
              end else if (!q[0]) begin
                low_byte_hold <= byte_value;
              end else begin
                unique case (field)
                  2'd0:    step_delta[hdr_ch]      <= {byte_value, low_byte_hold};
                  2'd1:    previous_sample[hdr_ch] <= {byte_value, low_byte_hold};
                  default: older_sample[hdr_ch]    <= {byte_value, low_byte_hold};
                endcase
              end
              if (last_hdr) begin
                samples_emitted <= stereo ? 15'd4 : 15'd2;
                seed_cnt        <= '0;
                state           <= ST_SEED;
              end
            end else begin
              code_byte <= byte_value;
              code_sel  <= 1'b0;
              if (samples_emitted < limit) begin
                chan  <= stereo ? samples_emitted[0] : 1'b0;
                state <= ST_MUL0;
              end
            end
          end
        end
        ST_SEED: begin
          if (out_free) begin
            sample       <= seed_older ? older_sample[seed_ch] : previous_sample[seed_ch];
            channel_id   <= seed_ch;
            last         <= seed_last;
            block_end    <= seed_last && (limit <= (stereo ? 15'd4 : 15'd2));
            seed_cnt     <= seed_cnt + 2'd1;
            if (seed_last) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_MUL0: begin
          acc   <= prod_ext;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          acc   <= acc + prod_ext;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          acc   <= (acc >>> 8) + prod_ext;
          state <= ST_MUL3;
        end
        ST_MUL3: begin
          if (out_free) begin
            sample                <= sat;
            channel_id            <= chan;
            last                  <= code_sel || (se_inc == limit);
            block_end             <= se_inc == limit;
            step_delta[chan]      <= delta_new;
            older_sample[chan]    <= previous_sample[chan];
            previous_sample[chan] <= sat;
            samples_emitted       <= se_inc;
            if (!code_sel && (se_inc < limit)) begin
              code_sel <= 1'b1;
              chan     <= stereo ? se_inc[0] : 1'b0;
              state    <= ST_MUL0;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/msadpcm_checker.sv @@
// Port-level checks of the ADPCM block decoder, bound to its top level.
// Depends on ms_adpcm_block_decoder_macros.svh.
`include "ms_adpcm_block_decoder_macros.svh"

module msadpcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_ready,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic [15:0] sample,
  input logic        channel_id,
  input logic        last,
  input logic        block_end
);

  `MSADPCM_ASSERT(a_out_hold, clk, rst, sample_valid && !sample_ready |=> sample_valid && $stable(sample) && $stable(channel_id) && $stable(last) && $stable(block_end), "stalled sample transaction changed")
  `MSADPCM_ASSERT_RST(a_reset_idle, clk, rst |=> byte_ready && !sample_valid, "decoder not idle after reset")
  `MSADPCM_ASSERT(a_end_is_last, clk, rst, sample_valid && block_end |-> last, "block end not on last sample of byte")
  `MSADPCM_ASSERT(a_busy_no_byte, clk, rst, byte_valid && !byte_ready |=> byte_valid, "byte transaction dropped while busy")

endmodule

bind ms_adpcm_block_decoder msadpcm_checker u_msadpcm_checker (.*);
